/* src/lpht_pkg.sv */
// Shared types and constants for the linear probing hash table.
`default_nettype none
package lpht_pkg;

  // Number of slots; must be a power of two so the home slot is a bit-select of the key.
  localparam int TABLE_SIZE = 256;
  localparam int IDX_W      = $clog2(TABLE_SIZE);
  localparam int KEY_W      = 31;
  localparam int DATA_W     = 32;
  localparam int ACT_W      = 2;

  // Request codes; the fourth code is a no-op request
  typedef enum logic [ACT_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_GET    = 2'd2
  } action_t;

  // Slot occupancy codes
  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_USED    = 2'd1,
    ST_DELETED = 2'd2
  } slot_status_t;

  // One word of the slot store
  typedef struct packed {
    slot_status_t        status;
    logic [KEY_W-1:0]    key;
    logic [DATA_W-1:0]   payload;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Controller states
  typedef enum logic {
    CS_IDLE,
    CS_PROBE
  } ctrl_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic         load;       // capture the request beat, read the home slot
    logic         advance;    // move to the next slot and read it
    logic         wr_en;      // write the current slot
    slot_status_t wr_status;  // status written; used takes the request key/payload
    logic         res_load;   // load the result register
    logic         res_hit;
    logic         res_full;
    logic         res_rd;     // result carries the payload of the current slot
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [ACT_W-1:0] action;
    logic             slot_free;   // current slot is empty or deleted
    logic             slot_empty;
    logic             key_match;   // current slot used and holds the key
    logic             wrap;        // the next slot is the home slot
    logic             out_free;    // result register can take a new beat
  } status_t;

endpackage
`default_nettype wire

/* src/lpht_req_if.sv */
// Request channel: action, key and payload with valid/ready.
`default_nettype none
interface lpht_req_if;
  logic                        valid;
  logic                        ready;
  logic [lpht_pkg::ACT_W-1:0]  action;
  logic [lpht_pkg::KEY_W-1:0]  key;
  logic [lpht_pkg::DATA_W-1:0] payload;

  modport source (output valid, output action, output key, output payload, input ready);
  modport sink   (input valid, input action, input key, input payload, output ready);
endinterface
`default_nettype wire

/* src/lpht_rsp_if.sv */
// Response channel: hit, table_full and read_payload with valid/ready.
`default_nettype none
interface lpht_rsp_if;
  logic                        valid;
  logic                        ready;
  logic                        hit;
  logic                        table_full;
  logic [lpht_pkg::DATA_W-1:0] read_payload;

  modport source (output valid, output hit, output table_full, output read_payload,
                  input ready);
  modport sink   (input valid, input hit, input table_full, input read_payload,
                  output ready);
endinterface
`default_nettype wire

/* src/lpht_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module lpht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* src/lpht_ctrl.sv */
// Probe sequencer: walks the probe path and decides write and result per slot.
`default_nettype none
module lpht_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire lpht_pkg::status_t status,
  output lpht_pkg::cmd_t         cmd
);

  lpht_pkg::ctrl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lpht_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lpht_pkg::CS_IDLE: begin
        if (req_valid) begin
          state_next = lpht_pkg::CS_PROBE;
        end
      end
      lpht_pkg::CS_PROBE: begin
        if (cmd.res_load) begin
          state_next = lpht_pkg::CS_IDLE;
        end
      end
      default: state_next = lpht_pkg::CS_IDLE;
    endcase
  end

  // Outputs: one slot examined per cycle in the probe state while the result register can take a beat
  always_comb begin
    cmd           = '0;
    cmd.wr_status = lpht_pkg::ST_USED;
    req_ready     = 1'b0;
    unique case (state)
      lpht_pkg::CS_IDLE: begin
        req_ready = 1'b1;
        cmd.load  = req_valid;
      end
      lpht_pkg::CS_PROBE: begin
        // hold the current slot while the result register is occupied
        if (status.out_free) begin
          unique case (status.action)
            lpht_pkg::ACT_INSERT: begin
              if (status.slot_free) begin
                cmd.wr_en     = 1'b1;
                cmd.wr_status = lpht_pkg::ST_USED;
                cmd.res_load  = 1'b1;
                cmd.res_hit   = 1'b1;
              end else if (status.wrap) begin
                cmd.res_load = 1'b1;
                cmd.res_full = 1'b1;
              end else begin
                cmd.advance = 1'b1;
              end
            end
            lpht_pkg::ACT_DELETE, lpht_pkg::ACT_GET: begin
              if (status.slot_empty) begin
                cmd.res_load = 1'b1;
              end else if (status.key_match) begin
                cmd.res_load = 1'b1;
                cmd.res_hit  = 1'b1;
                if (status.action == lpht_pkg::ACT_DELETE) begin
                  cmd.wr_en     = 1'b1;
                  cmd.wr_status = lpht_pkg::ST_DELETED;
                end else begin
                  cmd.res_rd = 1'b1;
                end
              end else if (status.wrap) begin
                cmd.res_load = 1'b1;
              end else begin
                cmd.advance = 1'b1;
              end
            end
            // unused code: empty result, table untouched
            default: cmd.res_load = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

/* src/lpht_dp.sv */
// Datapath: request registers, probe index, slot store, valid bits, result register.
`default_nettype none
module lpht_dp (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic [lpht_pkg::ACT_W-1:0]  req_action,
  input  wire logic [lpht_pkg::KEY_W-1:0]  req_key,
  input  wire logic [lpht_pkg::DATA_W-1:0] req_payload,
  input  wire lpht_pkg::cmd_t              cmd,
  output lpht_pkg::status_t                status,
  output logic                             rsp_valid,
  input  wire logic                        rsp_ready,
  output logic                             rsp_hit,
  output logic                             rsp_table_full,
  output logic [lpht_pkg::DATA_W-1:0]      rsp_read_payload
);

  logic [lpht_pkg::ACT_W-1:0]  action;
  logic [lpht_pkg::KEY_W-1:0]  key;
  logic [lpht_pkg::DATA_W-1:0] payload;
  logic [lpht_pkg::IDX_W-1:0]  home;
  logic [lpht_pkg::IDX_W-1:0]  idx;
  logic [lpht_pkg::IDX_W-1:0]  idx_inc;
  logic [lpht_pkg::IDX_W-1:0]  raddr;
  logic [lpht_pkg::TABLE_SIZE-1:0] written;
  logic                        rd_written;
  logic [lpht_pkg::SLOT_W-1:0] rd_bits;
  lpht_pkg::slot_t             rd_slot;
  lpht_pkg::slot_t             wr_slot;
  lpht_pkg::slot_status_t      cur_status;

  assign idx_inc = idx + lpht_pkg::IDX_W'(1);

  // Read address: home slot on a new beat, next slot when advancing
  always_comb begin
    priority if (cmd.load) begin
      raddr = req_key[lpht_pkg::IDX_W-1:0];
    end else if (cmd.advance) begin
      raddr = idx_inc;
    end else begin
      raddr = idx;
    end
  end

  // Request capture and probe index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action  <= req_action;
      key     <= req_key;
      payload <= req_payload;
      home    <= req_key[lpht_pkg::IDX_W-1:0];
    end
    idx <= raddr;
  end

  // Slot store
  lpht_ram #(
    .WIDTH (lpht_pkg::SLOT_W),
    .DEPTH (lpht_pkg::TABLE_SIZE)
  ) u_slots (
    .clk   (clk),
    .we    (cmd.wr_en),
    .waddr (idx),
    .wdata (wr_slot),
    .raddr (raddr),
    .rdata (rd_bits)
  );

  // Written flags: a slot never written reads as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        written[idx] <= 1'b1;
      end
      rd_written <= written[raddr];
    end
  end

  assign rd_slot    = lpht_pkg::slot_t'(rd_bits);
  assign cur_status = rd_written ? rd_slot.status : lpht_pkg::ST_EMPTY;

  // Write word: insert stores the request, delete keeps key and payload
  always_comb begin
    wr_slot.status = cmd.wr_status;
    if (cmd.wr_status == lpht_pkg::ST_USED) begin
      wr_slot.key     = key;
      wr_slot.payload = payload;
    end else begin
      wr_slot.key     = rd_slot.key;
      wr_slot.payload = rd_slot.payload;
    end
  end

  // Status to the controller
  always_comb begin
    status.action     = action;
    status.slot_free  = (cur_status != lpht_pkg::ST_USED);
    status.slot_empty = (cur_status == lpht_pkg::ST_EMPTY);
    status.key_match  = (cur_status == lpht_pkg::ST_USED) && (rd_slot.key == key);
    status.wrap       = (idx_inc == home);
    status.out_free   = !rsp_valid || rsp_ready;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.res_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      rsp_hit          <= cmd.res_hit;
      rsp_table_full   <= cmd.res_full;
      rsp_read_payload <= cmd.res_rd ? rd_slot.payload : '0;
    end
  end

endmodule
`default_nettype wire

/* src/linear_probe_hash_table.sv */
// Top level of the linear probing hash table.
// Open-addressing hash table of lpht_pkg::TABLE_SIZE slots with linear probing and
// tombstones. Each request beat (insert, delete or get) yields exactly one response
// beat. The home slot is the low bits of the key; the probe examines one slot per
// clock from a single-port-read slot RAM while the output register can take a result;
// a request examines P slots, where P (1 to TABLE_SIZE) is the number of slots
// on its probe path up to a free slot, a match, an empty slot or the wrap back to
// home. One request is handled at a time; a new request is accepted while the
// previous response still waits in the output register. Slot occupancy is tracked
// by per-slot written flags cleared at reset, so the table is usable straight after
// reset with no clearing pass. Insert never checks for an existing copy of the key.
`default_nettype none
module linear_probe_hash_table (
  input wire logic clk,
  input wire logic rst,
  lpht_req_if.sink   request,
  lpht_rsp_if.source response
);

  lpht_pkg::cmd_t    cmd;
  lpht_pkg::status_t status;

  lpht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .status    (status),
    .cmd       (cmd)
  );

  lpht_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .req_action       (request.action),
    .req_key          (request.key),
    .req_payload      (request.payload),
    .cmd              (cmd),
    .status           (status),
    .rsp_valid        (response.valid),
    .rsp_ready        (response.ready),
    .rsp_hit          (response.hit),
    .rsp_table_full   (response.table_full),
    .rsp_read_payload (response.read_payload)
  );

endmodule
`default_nettype wire

/* tb/tb_linear_probe_hash_table.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the linear probing hash table, with a shadow slot store.
module tb_linear_probe_hash_table;

  // The fourth request code is a no-op
  localparam logic [lpht_pkg::ACT_W-1:0]  ACT_NOP    = 2'd3;
  localparam logic [lpht_pkg::KEY_W-1:0]  KEY_MAX    = {lpht_pkg::KEY_W{1'b1}};
  localparam logic [lpht_pkg::DATA_W-1:0] DATA_MAX   = {lpht_pkg::DATA_W{1'b1}};
  localparam int                          MAX_PRINTS = 40;

  typedef struct packed {
    logic [lpht_pkg::ACT_W-1:0]  action;
    logic [lpht_pkg::KEY_W-1:0]  key;
    logic [lpht_pkg::DATA_W-1:0] payload;
  } request_t;

  typedef struct packed {
    logic                        hit;
    logic                        table_full;
    logic [lpht_pkg::DATA_W-1:0] read_payload;
  } outcome_t;

  logic clk;
  logic rst;

  lpht_req_if req_bus ();
  lpht_rsp_if rsp_bus ();

  linear_probe_hash_table u_top (
    .clk      (clk),
    .rst      (rst),
    .request  (req_bus),
    .response (rsp_bus)
  );

  // Shadow copy of the slot store
  lpht_pkg::slot_status_t      shadow_status  [lpht_pkg::TABLE_SIZE];
  logic [lpht_pkg::KEY_W-1:0]  shadow_key     [lpht_pkg::TABLE_SIZE];
  logic [lpht_pkg::DATA_W-1:0] shadow_payload [lpht_pkg::TABLE_SIZE];

  request_t                   request_q [$];   // beats waiting to be driven
  outcome_t                   outcome_q [$];   // predicted responses, oldest first
  logic [lpht_pkg::KEY_W-1:0] live_keys [$];   // keys believed stored
  request_t                   drive_beat;
  outcome_t                   want;
  int unsigned                beats_in;
  int unsigned                beats_out;
  int unsigned                error_cnt;

  // Clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Reset and known input levels from time zero
  initial begin
    rst             = 1'b1;
    req_bus.valid   = 1'b0;
    req_bus.action  = '0;
    req_bus.key     = '0;
    req_bus.payload = '0;
    rsp_bus.ready   = 1'b0;
    beats_in        = 0;
    beats_out       = 0;
    error_cnt       = 0;
    for (int i = 0; i < lpht_pkg::TABLE_SIZE; i++) begin
      shadow_status[i] = lpht_pkg::ST_EMPTY;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // Apply one request to the shadow store and return the response it should give
  function automatic outcome_t table_apply(request_t r);
    outcome_t o;
    int       home;
    int       s;
    o    = '0;
    home = int'(r.key % lpht_pkg::TABLE_SIZE);
    case (r.action)
      lpht_pkg::ACT_INSERT: begin
        o.table_full = 1'b1;
        for (int n = 0; n < lpht_pkg::TABLE_SIZE; n++) begin
          s = (home + n) % lpht_pkg::TABLE_SIZE;
          if (shadow_status[s] != lpht_pkg::ST_USED) begin
            shadow_status[s]  = lpht_pkg::ST_USED;
            shadow_key[s]     = r.key;
            shadow_payload[s] = r.payload;
            o.hit             = 1'b1;
            o.table_full      = 1'b0;
            break;
          end
        end
      end
      lpht_pkg::ACT_DELETE, lpht_pkg::ACT_GET: begin
        // stop at an empty slot, the first used match, or after a full lap
        for (int n = 0; n < lpht_pkg::TABLE_SIZE; n++) begin
          s = (home + n) % lpht_pkg::TABLE_SIZE;
          if (shadow_status[s] == lpht_pkg::ST_EMPTY) break;
          if (shadow_status[s] == lpht_pkg::ST_USED && shadow_key[s] == r.key) begin
            o.hit = 1'b1;
            if (r.action == lpht_pkg::ACT_DELETE) shadow_status[s] = lpht_pkg::ST_DELETED;
            else o.read_payload = shadow_payload[s];
            break;
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Idling pattern changes every 40 accepted beats: none, sender, receiver, both
  function automatic bit roll_pause(bit receiver);
    int unsigned mode;
    mode = (beats_in / 40) % 4;
    case (mode)
      1:       return !receiver && $urandom_range(0, 99) < 61;
      2:       return receiver && $urandom_range(0, 99) < 61;
      3:       return $urandom_range(0, 99) < 17;
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    error_cnt++;
    if (error_cnt <= MAX_PRINTS) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [lpht_pkg::DATA_W-1:0] got,
                             logic [lpht_pkg::DATA_W-1:0] exp);
    if (got !== exp)
      report_mismatch($sformatf("response %0d %s: got %0h, expected %0h",
                                beats_out, name, got, exp));
  endtask

  // Request driver: next beat from the queue once the previous one has gone
  always @(posedge clk) begin
    if (rst) begin
      req_bus.valid <= 1'b0;
    end else if (!req_bus.valid || req_bus.ready) begin
      if (request_q.size() != 0 && !roll_pause(1'b0)) begin
        drive_beat       = request_q.pop_front();
        req_bus.valid   <= 1'b1;
        req_bus.action  <= drive_beat.action;
        req_bus.key     <= drive_beat.key;
        req_bus.payload <= drive_beat.payload;
      end else begin
        req_bus.valid <= 1'b0;
      end
    end
  end

  // Response back-pressure
  always @(posedge clk) begin
    if (rst) rsp_bus.ready <= 1'b0;
    else rsp_bus.ready <= !roll_pause(1'b1);
  end

  // Monitor: check response beats, predict on accepted request beats
  always @(posedge clk) begin
    if (!rst) begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (outcome_q.size() == 0) begin
          report_mismatch("response beat with no request outstanding");
        end else begin
          want = outcome_q.pop_front();
          check_field("hit", lpht_pkg::DATA_W'(rsp_bus.hit), lpht_pkg::DATA_W'(want.hit));
          check_field("table_full", lpht_pkg::DATA_W'(rsp_bus.table_full),
                      lpht_pkg::DATA_W'(want.table_full));
          check_field("read_payload", rsp_bus.read_payload, want.read_payload);
        end
        beats_out <= beats_out + 1;
      end
      if (req_bus.valid && req_bus.ready) begin
        outcome_q.push_back(table_apply({req_bus.action, req_bus.key, req_bus.payload}));
        beats_in <= beats_in + 1;
      end
    end
  end

  // Keys bunched on a few home slots, some near the top so probes wrap
  function automatic logic [lpht_pkg::KEY_W-1:0] clustered_key();
    logic [lpht_pkg::KEY_W-1:0] k;
    int unsigned                pick;
    k    = lpht_pkg::KEY_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 3) k = '0;
    else if (pick < 6) k = KEY_MAX;
    else if (pick < 45) k[lpht_pkg::IDX_W-1:0] = lpht_pkg::IDX_W'($urandom_range(0, 23));
    else if (pick < 70)
      k[lpht_pkg::IDX_W-1:0] = lpht_pkg::IDX_W'($urandom_range(lpht_pkg::TABLE_SIZE - 12,
                                                               lpht_pkg::TABLE_SIZE - 1));
    return k;
  endfunction

  function automatic logic [lpht_pkg::DATA_W-1:0] any_payload();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 10) return DATA_MAX;
    return lpht_pkg::DATA_W'($urandom);
  endfunction

  // A key likely to be stored; take removes it from the pool
  function automatic logic [lpht_pkg::KEY_W-1:0] pool_key(bit take);
    logic [lpht_pkg::KEY_W-1:0] k;
    int unsigned                idx;
    if (live_keys.size() == 0) return clustered_key();
    idx = $urandom_range(0, live_keys.size() - 1);
    k   = live_keys[idx];
    if (take) live_keys.delete(idx);
    return k;
  endfunction

  task automatic queue_req(logic [lpht_pkg::ACT_W-1:0] act, logic [lpht_pkg::KEY_W-1:0] key,
                           logic [lpht_pkg::DATA_W-1:0] payload);
    request_t r;
    r.action  = act;
    r.key     = key;
    r.payload = payload;
    request_q.push_back(r);
    if (act == lpht_pkg::ACT_INSERT) live_keys.push_back(key);
  endtask

  // One random request; weights for insert, get and delete, no-op now and then
  task automatic mixed_request(int unsigned ins_w, int unsigned get_w, int unsigned del_w);
    int unsigned roll;
    roll = $urandom_range(0, ins_w + get_w + del_w + 3);
    if (roll < ins_w)
      queue_req(lpht_pkg::ACT_INSERT, clustered_key(), any_payload());
    else if (roll < ins_w + get_w)
      queue_req(lpht_pkg::ACT_GET,
                ($urandom_range(0, 4) != 0) ? pool_key(1'b0) : clustered_key(),
                any_payload());
    else if (roll < ins_w + get_w + del_w)
      queue_req(lpht_pkg::ACT_DELETE,
                ($urandom_range(0, 4) != 0) ? pool_key(1'b1) : clustered_key(),
                any_payload());
    else
      queue_req(ACT_NOP, clustered_key(), any_payload());
  endtask

  // Stimulus and end of run
  initial begin
    // misses on an empty table and a no-op
    queue_req(lpht_pkg::ACT_GET, '0, '0);
    queue_req(lpht_pkg::ACT_DELETE, lpht_pkg::KEY_W'(5), DATA_MAX);
    queue_req(ACT_NOP, KEY_MAX, DATA_MAX);
    // extremes, and a collision on the top slot that wraps to the bottom
    queue_req(lpht_pkg::ACT_INSERT, '0, '0);
    queue_req(lpht_pkg::ACT_INSERT, KEY_MAX, DATA_MAX);
    queue_req(lpht_pkg::ACT_INSERT, lpht_pkg::KEY_W'(32'h1FF), 32'h1234_5678);
    queue_req(lpht_pkg::ACT_GET, lpht_pkg::KEY_W'(32'h1FF), '0);
    queue_req(lpht_pkg::ACT_GET, KEY_MAX, '0);
    queue_req(lpht_pkg::ACT_GET, lpht_pkg::KEY_W'(32'h100), '0);
    // duplicate key: first copy wins until it is deleted
    queue_req(lpht_pkg::ACT_INSERT, '0, 32'hA5A5_A5A5);
    queue_req(lpht_pkg::ACT_GET, '0, DATA_MAX);
    queue_req(lpht_pkg::ACT_DELETE, '0, '0);
    queue_req(lpht_pkg::ACT_GET, '0, '0);
    queue_req(lpht_pkg::ACT_DELETE, '0, '0);
    queue_req(lpht_pkg::ACT_GET, '0, '0);
    queue_req(lpht_pkg::ACT_DELETE, '0, '0);
    // tombstone reuse, then probe through the wrap again
    queue_req(lpht_pkg::ACT_INSERT, lpht_pkg::KEY_W'(32'h100), 32'h5A5A_5A5A);
    queue_req(lpht_pkg::ACT_GET, lpht_pkg::KEY_W'(32'h1FF), '0);
    queue_req(ACT_NOP, '0, '0);
    queue_req(lpht_pkg::ACT_GET, lpht_pkg::KEY_W'(32'h100), '0);
    live_keys.delete();
    live_keys.push_back(KEY_MAX);
    live_keys.push_back(lpht_pkg::KEY_W'(32'h1FF));
    live_keys.push_back(lpht_pkg::KEY_W'(32'h100));

    // growth with collisions
    repeat (380) mixed_request(5, 3, 2);
    // fill to the brim; only gets and no-ops on the side so the table ends full
    repeat (265) begin
      queue_req(lpht_pkg::ACT_INSERT, clustered_key(), any_payload());
      if ($urandom_range(0, 7) == 0) mixed_request(0, 1, 0);
    end
    // full table: rejected inserts, gets that lap the whole table
    repeat (30) mixed_request(1, 1, 0);
    repeat (60) mixed_request(4, 4, 1);
    // drain, leaving tombstones everywhere
    repeat (220) mixed_request(1, 3, 6);
    repeat (200) mixed_request(4, 3, 3);

    wait (rst === 1'b0);
    while (request_q.size() != 0 || req_bus.valid || outcome_q.size() != 0) @(negedge clk);
    repeat (300) @(posedge clk);
    if (error_cnt == 0) begin
      $display("linear_probe_hash_table verification clean");
    end else begin
      $display("linear_probe_hash_table verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #15_000_000;
    $display("linear_probe_hash_table verification failed");
    $finish;
  end

endmodule
